FILE: rtl/qdqf_pkg.sv
package qdqf_pkg;

  // width of every q factor, unsigned fixed point
  localparam int Q_WIDTH = 24;

  // default geometry
  localparam int COORD_BITS_DEF  = 16;
  localparam int Q_FRAC_BITS_DEF = 16;

endpackage

FILE: rtl/qdqf_corner_if.sv
interface qdqf_corner_if import qdqf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] corner0_x;
  logic signed [COORD_BITS-1:0] corner0_y;
  logic signed [COORD_BITS-1:0] corner1_x;
  logic signed [COORD_BITS-1:0] corner1_y;
  logic signed [COORD_BITS-1:0] corner2_x;
  logic signed [COORD_BITS-1:0] corner2_y;
  logic signed [COORD_BITS-1:0] corner3_x;
  logic signed [COORD_BITS-1:0] corner3_y;

  modport source (
    output valid,
    output corner0_x, corner0_y, corner1_x, corner1_y,
    output corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );

  modport sink (
    input  valid,
    input  corner0_x, corner0_y, corner1_x, corner1_y,
    input  corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );

endinterface

FILE: rtl/qdqf_q_if.sv
interface qdqf_q_if import qdqf_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [Q_WIDTH-1:0] q_corner0;
  logic [Q_WIDTH-1:0] q_corner1;
  logic [Q_WIDTH-1:0] q_corner2;
  logic [Q_WIDTH-1:0] q_corner3;
  logic               updated;

  modport source (
    output valid,
    output q_corner0, q_corner1, q_corner2, q_corner3, updated,
    input  ready
  );

  modport sink (
    input  valid,
    input  q_corner0, q_corner1, q_corner2, q_corner3, updated,
    output ready
  );

endinterface

FILE: rtl/qdqf_cross.sv
// bit-serial signed shift-and-add for the three cross products
module qdqf_cross import qdqf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS:0]   ax_i,
  input  logic signed [COORD_BITS:0]   ay_i,
  input  logic signed [COORD_BITS:0]   bx_i,
  input  logic signed [COORD_BITS:0]   by_i,
  input  logic signed [COORD_BITS:0]   cx_i,
  input  logic signed [COORD_BITS:0]   cy_i,
  output logic [2*COORD_BITS+1:0]      crs_o,
  output logic [2*COORD_BITS+1:0]      ns_o,
  output logic [2*COORD_BITS+1:0]      nt_o,
  output logic                         done_o
);

  localparam int DiffW = COORD_BITS + 1;
  localparam int ProdW = 2 * COORD_BITS + 2;
  localparam int CntW  = $clog2(DiffW + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [ProdW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [DiffW-1:0] mby_q, mbx_q, mcy_q, mcx_q;
  logic [ProdW-1:0] crs_q, ns_q, nt_q;
  logic [ProdW-1:0] crs_t, ns_t, nt_t;
  logic [ProdW-1:0] crs_d, ns_d, nt_d;
  logic             last;

  assign last = (cnt_q == CntW'(DiffW - 1));

  always_comb begin
    crs_t = (mby_q[0] ? ax_q : '0) - (mbx_q[0] ? ay_q : '0);
    ns_t  = (mcy_q[0] ? ax_q : '0) - (mcx_q[0] ? ay_q : '0);
    nt_t  = (mcy_q[0] ? bx_q : '0) - (mcx_q[0] ? by_q : '0);
    // the sign bit of the multiplier weighs negative
    if (last) begin
      crs_d = crs_q - crs_t;
      ns_d  = ns_q - ns_t;
      nt_d  = nt_q - nt_t;
    end else begin
      crs_d = crs_q + crs_t;
      ns_d  = ns_q + ns_t;
      nt_d  = nt_q + nt_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ax_q  <= ProdW'(ax_i);
      ay_q  <= ProdW'(ay_i);
      bx_q  <= ProdW'(bx_i);
      by_q  <= ProdW'(by_i);
      mby_q <= by_i;
      mbx_q <= bx_i;
      mcy_q <= cy_i;
      mcx_q <= cx_i;
      crs_q <= '0;
      ns_q  <= '0;
      nt_q  <= '0;
    end else if (busy_q) begin
      ax_q  <= ax_q << 1;
      ay_q  <= ay_q << 1;
      bx_q  <= bx_q << 1;
      by_q  <= by_q << 1;
      mby_q <= mby_q >> 1;
      mbx_q <= mbx_q >> 1;
      mcy_q <= mcy_q >> 1;
      mcx_q <= mcx_q >> 1;
      crs_q <= crs_d;
      ns_q  <= ns_d;
      nt_q  <= nt_d;
    end
  end

  assign crs_o  = crs_q;
  assign ns_o   = ns_q;
  assign nt_o   = nt_q;
  assign done_o = done_q;

endmodule

FILE: rtl/qdqf_div.sv
// restoring divider, one quotient bit per cycle, rounded and saturated
module qdqf_div import qdqf_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int Q_FRAC_BITS = Q_FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2*COORD_BITS:0]   num_i,
  input  logic [2*COORD_BITS:0]   den_i,
  output logic [Q_WIDTH-1:0]      quot_o,
  output logic                    done_o
);

  localparam int NumW  = 2 * COORD_BITS + 1;
  // integer bits, fraction bits and one extra bit for rounding
  localparam int Steps = NumW + Q_FRAC_BITS + 1;
  localparam int CntW  = $clog2(Steps);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [NumW-1:0]  dvd_q, rem_q, den_q;
  logic [Q_WIDTH:0] quo_q;
  logic             ovf_q;

  logic [NumW:0]      rem_sh, rem_sub;
  logic [NumW-1:0]    rem_d;
  logic               ge;
  logic               last;
  logic [Q_WIDTH+1:0] rnd;

  assign last    = (cnt_q == CntW'(Steps - 1));
  assign rem_sh  = {rem_q, dvd_q[NumW-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rem_d   = ge ? rem_sub[NumW-1:0] : rem_sh[NumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[Q_WIDTH-1:0], ge};
      // a one shifted past the kept bits means the result saturates
      ovf_q <= ovf_q | quo_q[Q_WIDTH];
    end
  end

  // round half up on the extra bit
  assign rnd    = {1'b0, quo_q} + (Q_WIDTH + 2)'(1);
  assign quot_o = (ovf_q || rnd[Q_WIDTH+1]) ? '1 : rnd[Q_WIDTH:1];
  assign done_o = done_q;

endmodule

FILE: rtl/quad_diagonal_q_factors.sv
// Perspective q factors of a screen quad from the crossing of its diagonals.
// corner_i (sink) takes one request with the four corners as signed pixel
// coordinates; q_o (source) returns one request per input with q_corner0..3
// (unsigned, Q_FRAC_BITS fraction bits, saturated) and updated. When the
// diagonals cross strictly inside both segments the factors 1/(1-t), 1/(1-s),
// 1/t and 1/s are computed and stored; otherwise the stored ones come back
// with updated low.
// Sequence: a bit-serial multiplier forms the three cross products, then one
// serial restoring divider runs four times, once per corner. One request is in
// work at a time; corner_i.ready is high only while the datapath is idle.
// The result sits in an output register, so a new request is taken while the
// previous result waits; if q_o is stalled when the next result is done, the
// datapath holds in its final state until q_o.ready.
// Reset clears the control and sets all stored factors to 1.0.
module quad_diagonal_q_factors import qdqf_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int Q_FRAC_BITS = Q_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qdqf_corner_if.sink corner_i,
  qdqf_q_if.source    q_o
);

  localparam int DiffW = COORD_BITS + 1;
  localparam int ProdW = 2 * COORD_BITS + 2;
  localparam int NumW  = 2 * COORD_BITS + 1;

  // 1.0 in q format, saturated when the fraction fills the word
  localparam logic [Q_WIDTH:0]   QOneWide = (Q_WIDTH + 1)'(1) << Q_FRAC_BITS;
  localparam logic [Q_WIDTH-1:0] QOne     = QOneWide[Q_WIDTH] ? {Q_WIDTH{1'b1}}
                                                              : QOneWide[Q_WIDTH-1:0];

  // sequencer states
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StMul    = 3'd1;
  localparam logic [2:0] StCheck  = 3'd2;
  localparam logic [2:0] StDivGo  = 3'd3;
  localparam logic [2:0] StDivRun = 3'd4;
  localparam logic [2:0] StFin    = 3'd5;

  // divider pass order: corners 0..3
  localparam logic [1:0] IdxLast = 2'd3;

  logic [2:0] state_q;
  logic [1:0] idx_q;
  logic       upd_q;

  logic [ProdW-1:0] crs_q, ns_q, nt_q;
  logic [Q_WIDTH-1:0] held_q [4];
  logic [Q_WIDTH-1:0] out_q  [4];
  logic               out_upd_q;
  logic               out_valid_q;

  logic in_acc;
  logic fin_load;

  // corner differences
  logic signed [DiffW-1:0] ax, ay, bx, by, cx, cy;

  // cross unit
  logic [ProdW-1:0] mul_crs, mul_ns, mul_nt;
  logic             mul_done;
  logic             mul_neg;

  // divider
  logic [NumW-1:0]    div_num, div_den;
  logic [Q_WIDTH-1:0] div_quot;
  logic               div_done;
  logic               div_start;

  logic inside_ok;

  assign corner_i.ready = (state_q == StIdle);
  assign in_acc         = corner_i.valid && corner_i.ready;

  // a = p2 - p0, b = p3 - p1, c = p0 - p1
  assign ax = DiffW'(corner_i.corner2_x) - DiffW'(corner_i.corner0_x);
  assign ay = DiffW'(corner_i.corner2_y) - DiffW'(corner_i.corner0_y);
  assign bx = DiffW'(corner_i.corner3_x) - DiffW'(corner_i.corner1_x);
  assign by = DiffW'(corner_i.corner3_y) - DiffW'(corner_i.corner1_y);
  assign cx = DiffW'(corner_i.corner0_x) - DiffW'(corner_i.corner1_x);
  assign cy = DiffW'(corner_i.corner0_y) - DiffW'(corner_i.corner1_y);

  qdqf_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .ax_i   (ax),
    .ay_i   (ay),
    .bx_i   (bx),
    .by_i   (by),
    .cx_i   (cx),
    .cy_i   (cy),
    .crs_o  (mul_crs),
    .ns_o   (mul_ns),
    .nt_o   (mul_nt),
    .done_o (mul_done)
  );

  // flip all three so the cross product is positive
  assign mul_neg = mul_crs[ProdW-1];

  // strict 0 < t < 1 and 0 < s < 1 with a nonzero cross product
  assign inside_ok = (crs_q != '0)
                  && !ns_q[ProdW-1] && (ns_q != '0) && (ns_q < crs_q)
                  && !nt_q[ProdW-1] && (nt_q != '0) && (nt_q < crs_q);

  // denominators: 1-t, 1-s, t, s scaled by the cross product
  always_comb begin
    case (idx_q)
      2'd0:    div_den = crs_q[NumW-1:0] - nt_q[NumW-1:0];
      2'd1:    div_den = crs_q[NumW-1:0] - ns_q[NumW-1:0];
      2'd2:    div_den = nt_q[NumW-1:0];
      default: div_den = ns_q[NumW-1:0];
    endcase
  end

  assign div_num   = crs_q[NumW-1:0];
  assign div_start = (state_q == StDivGo);

  qdqf_div #(
    .COORD_BITS (COORD_BITS),
    .Q_FRAC_BITS(Q_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quot_o (div_quot),
    .done_o (div_done)
  );

  // result moves to the output register once it is free or being drained
  assign fin_load = (state_q == StFin) && (!out_valid_q || q_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        held_q[i] <= QOne;
      end
    end else begin
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          if (mul_done) begin
            state_q <= StCheck;
          end
        end
        StCheck: begin
          idx_q <= '0;
          if (inside_ok) begin
            state_q <= StDivGo;
          end else begin
            upd_q   <= 1'b0;
            state_q <= StFin;
          end
        end
        StDivGo: begin
          state_q <= StDivRun;
        end
        StDivRun: begin
          if (div_done) begin
            held_q[idx_q] <= div_quot;
            if (idx_q == IdxLast) begin
              upd_q   <= 1'b1;
              state_q <= StFin;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= StDivGo;
            end
          end
        end
        StFin: begin
          if (fin_load) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (q_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StMul && mul_done) begin
      crs_q <= mul_neg ? (ProdW'(0) - mul_crs) : mul_crs;
      ns_q  <= mul_neg ? (ProdW'(0) - mul_ns)  : mul_ns;
      nt_q  <= mul_neg ? (ProdW'(0) - mul_nt)  : mul_nt;
    end
    if (fin_load) begin
      for (int i = 0; i < 4; i++) begin
        out_q[i] <= held_q[i];
      end
      out_upd_q <= upd_q;
    end
  end

  assign q_o.valid     = out_valid_q;
  assign q_o.q_corner0 = out_q[0];
  assign q_o.q_corner1 = out_q[1];
  assign q_o.q_corner2 = out_q[2];
  assign q_o.q_corner3 = out_q[3];
  assign q_o.updated   = out_upd_q;

endmodule
